FILE: design/register_vm_execute_unit_macros.svh
// Assertion macros shared by the checker of the register machine execute unit
`ifndef REGISTER_VM_EXECUTE_UNIT_MACROS_SVH
`define REGISTER_VM_EXECUTE_UNIT_MACROS_SVH

// Checked on every clock edge outside reset
`define RVX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define RVX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/rvx_pkg.sv
// Shared types and constants of the register machine execute unit
`default_nettype none
package rvx_pkg;

  localparam int unsigned FUNC_W      = 4;
  localparam int unsigned REG_FIELD_W = 6;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned INDEX_W     = 32;
  localparam int unsigned FLAG_W      = 2;

  localparam int unsigned DEF_REGISTER_COUNT = 64;
  localparam int unsigned DEF_DATA_WIDTH     = 32;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_CMP    = 4'd4,
    OP_COPY   = 4'd5,
    OP_JUMP   = 4'd6,
    OP_LOAD   = 4'd7,
    OP_INPUT  = 4'd8,
    OP_OUTPUT = 4'd9,
    OP_HALT   = 4'd10
  } op_t;

  localparam logic [REG_FIELD_W-1:0] COND_ALWAYS  = 6'd0;
  localparam logic [REG_FIELD_W-1:0] COND_ZERO    = 6'd1;
  localparam logic [REG_FIELD_W-1:0] COND_NZERO   = 6'd2;
  localparam logic [REG_FIELD_W-1:0] COND_POS     = 6'd3;
  localparam logic [REG_FIELD_W-1:0] COND_NEG     = 6'd4;
  localparam logic [REG_FIELD_W-1:0] COND_NNEG    = 6'd5;
  localparam logic [REG_FIELD_W-1:0] COND_NPOS    = 6'd6;

  localparam logic [FLAG_W-1:0] FLAG_ZERO = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_POS  = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_NEG  = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage
`default_nettype wire

FILE: design/rvx_in_if.sv
// Instruction channel: valid, ready and one instruction word
`default_nettype none
interface rvx_in_if import rvx_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [REG_FIELD_W-1:0] first_reg;
  logic [REG_FIELD_W-1:0] second_reg;
  logic signed [VALUE_W-1:0] immediate;
  logic signed [VALUE_W-1:0] entered_value;

  modport source(output valid, func, first_reg, second_reg, immediate, entered_value,
                 input ready);
  modport sink(input valid, func, first_reg, second_reg, immediate, entered_value,
               output ready);
endinterface
`default_nettype wire

FILE: design/rvx_out_if.sv
// Result channel: valid, ready and one result word
`default_nettype none
interface rvx_out_if import rvx_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      shown_valid;
  logic signed [VALUE_W-1:0] shown_value;
  logic                      branch_taken;
  logic [INDEX_W-1:0]        next_index;
  logic                      halted;
  logic                      divide_error;
  logic [FLAG_W-1:0]         sign_flag;

  modport source(output valid, shown_valid, shown_value, branch_taken, next_index,
                 halted, divide_error, sign_flag, input ready);
  modport sink(input valid, shown_valid, shown_value, branch_taken, next_index,
               halted, divide_error, sign_flag, output ready);
endinterface
`default_nettype wire

FILE: design/rvx_regfile.sv
// Register file memory: one write port, two registered read ports, reset by valid bits
`default_nettype none
module rvx_regfile import rvx_pkg::*; #(
  parameter int unsigned REGISTER_COUNT = DEF_REGISTER_COUNT,
  parameter int unsigned DATA_WIDTH     = DEF_DATA_WIDTH,
  localparam int unsigned IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en,
  input  wire logic [IW-1:0]         rd_addr_a,
  input  wire logic [IW-1:0]         rd_addr_b,
  output logic      [DATA_WIDTH-1:0] rd_data_a,
  output logic      [DATA_WIDTH-1:0] rd_data_b,
  input  wire logic                  wr_en,
  input  wire logic [IW-1:0]         wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0]     mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] written_r;
  logic [DATA_WIDTH-1:0]     da_r, db_r;
  logic                      va_r, vb_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      da_r <= mem[rd_addr_a];
      db_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        va_r <= written_r[rd_addr_a];
        vb_r <= written_r[rd_addr_b];
      end
    end
  end

  // an entry never written reads as zero
  assign rd_data_a = va_r ? da_r : '0;
  assign rd_data_b = vb_r ? db_r : '0;

endmodule
`default_nettype wire

FILE: design/rvx_alu.sv
// Serial ALU: bit-serial add/subtract, shift-add multiply, restoring divide
`default_nettype none
module rvx_alu import rvx_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire alu_req_t              req,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] res,
  output logic      [DATA_WIDTH-1:0] rem
);

  localparam int unsigned CW = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX, A_DONE} astate_t;

  astate_t               state_r, state_nxt;
  alu_op_t               op_r, op_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                  c_r, c_nxt, negq_r, negq_nxt, negr_r, negr_nxt;
  logic [DATA_WIDTH:0]   trial;
  logic                  sbit;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    c_nxt     = c_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    trial     = {z_r, x_r[DATA_WIDTH-1]} - {1'b0, y_r};
    sbit      = x_r[0] ^ y_r[0] ^ c_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          cnt_nxt   = CW'(DATA_WIDTH - 1);
          z_nxt     = '0;
          x_nxt     = a;
          y_nxt     = b;
          c_nxt     = 1'b0;
          state_nxt = A_RUN;
          case (req.op)
            ALU_SUB: begin
              y_nxt = ~b;
              c_nxt = 1'b1;
            end
            ALU_DIV: begin
              x_nxt    = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
              y_nxt    = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
              negq_nxt = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
              negr_nxt = a[DATA_WIDTH-1];
            end
            default: ;
          endcase
        end
      end
      A_RUN: begin
        case (op_r)
          ALU_ADD, ALU_SUB: begin
            // LSB first: sum bit into the top of the result shifter
            c_nxt = (x_r[0] & y_r[0]) | (x_r[0] & c_r) | (y_r[0] & c_r);
            x_nxt = x_r >> 1;
            y_nxt = y_r >> 1;
            z_nxt = {sbit, z_r[DATA_WIDTH-1:1]};
          end
          ALU_MUL: begin
            if (y_r[0]) begin
              z_nxt = z_r + x_r;
            end
            x_nxt = x_r << 1;
            y_nxt = y_r >> 1;
          end
          default: begin
            // one quotient bit per cycle
            if (!trial[DATA_WIDTH]) begin
              z_nxt = trial[DATA_WIDTH-1:0];
            end else begin
              z_nxt = {z_r[DATA_WIDTH-2:0], x_r[DATA_WIDTH-1]};
            end
            x_nxt = {x_r[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
          end
        endcase
        if (cnt_r == '0) begin
          state_nxt = A_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      A_FIX: begin
        if (op_r == ALU_DIV) begin
          z_nxt = negq_r ? (~x_r + 1'b1) : x_r;
          x_nxt = negr_r ? (~z_r + 1'b1) : z_r;
        end
        state_nxt = A_DONE;
      end
      A_DONE: state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    c_r    <= c_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign done = (state_r == A_DONE);
  assign res  = z_r;
  assign rem  = x_r;

endmodule
`default_nettype wire

FILE: design/register_vm_execute_unit.sv
// Top level of the register machine execute unit
//
//   channel   dir  handshake     word
//   in_ch     in   valid/ready   func, first_reg, second_reg, immediate, entered_value
//   out_ch    out  valid/ready   shown_valid, shown_value, branch_taken, next_index,
//                                halted, divide_error, sign_flag
//
// One instruction at a time. Add, sub, compare, multiply and divide run through the
// serial ALU, iteration plus fix-up, then write back; compare writes nothing, divide
// writes the remainder too, and a zero divisor skips both. Copy, load and input write
// the register file directly. The result word sits in an output register; the next
// instruction is taken while it waits, and only its own finish waits for the slot to drain.
// Synchronous reset clears flag, index and the register file valid bits.
`default_nettype none
module register_vm_execute_unit import rvx_pkg::*; #(
  parameter int unsigned REGISTER_COUNT = DEF_REGISTER_COUNT,
  parameter int unsigned DATA_WIDTH     = DEF_DATA_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rvx_in_if.sink    in_ch,
  rvx_out_if.source out_ch
);

  localparam int unsigned IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ALU, S_WB1, S_WB2, S_FIN} state_t;

  state_t                 state_r, state_nxt;
  logic [FUNC_W-1:0]      op_r;
  logic [REG_FIELD_W-1:0] code_r;
  logic [IW-1:0]          ia_r, ib_r;
  logic [VALUE_W-1:0]     imm_r, ent_r;
  logic [FLAG_W-1:0]      sign_r;
  logic [INDEX_W-1:0]     pc_r;

  logic                   ovalid_r, oshown_v_r, otaken_r, ohalt_r, oderr_r;
  logic [VALUE_W-1:0]     oshown_r;
  logic [INDEX_W-1:0]     onext_r;
  logic [FLAG_W-1:0]      oflag_r;

  logic                   in_acc, fin_load;
  logic [DATA_WIDTH-1:0]  rd_a, rd_b, alu_res, alu_rem, wr_data;
  logic                   alu_done, wr_en;
  logic [IW-1:0]          wr_addr;
  alu_req_t               alu_req;
  logic signed [63:0]     imm64, ent64, a64;
  logic                   taken, derr;
  logic [FLAG_W-1:0]      flag_new;

  function automatic logic [IW-1:0] reg_sel(input logic [REG_FIELD_W-1:0] f);
    logic [IW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << REG_FIELD_W); i++) begin
      if (f == REG_FIELD_W'(i)) begin
        r = IW'(i % REGISTER_COUNT);
      end
    end
    return r;
  endfunction

  function automatic logic [FLAG_W-1:0] flag_of(input logic [DATA_WIDTH-1:0] v);
    if (v == '0) begin
      return FLAG_ZERO;
    end
    return v[DATA_WIDTH-1] ? FLAG_NEG : FLAG_POS;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  rvx_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr_a(reg_sel(in_ch.first_reg)),
    .rd_addr_b(reg_sel(in_ch.second_reg)),
    .rd_data_a(rd_a),
    .rd_data_b(rd_b),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  rvx_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .a    (rd_a),
    .b    (rd_b),
    .done (alu_done),
    .res  (alu_res),
    .rem  (alu_rem)
  );

  assign imm64 = 64'(signed'(imm_r));
  assign ent64 = 64'(signed'(ent_r));
  assign a64   = 64'(signed'(rd_a));
  assign derr  = (op_r == OP_DIV) && (rd_b == '0);

  always_comb begin
    alu_req.start = (state_r == S_EXEC);
    case (op_r)
      OP_ADD:  alu_req.op = ALU_ADD;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_SUB;
    endcase
    case (op_r)
      OP_ADD, OP_SUB, OP_MUL, OP_CMP: alu_req.start = (state_r == S_EXEC);
      OP_DIV:  alu_req.start = (state_r == S_EXEC) && !derr;
      default: alu_req.start = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = (state_r == S_WB1) || (state_r == S_WB2);
    wr_addr = (state_r == S_WB2) ? ib_r : ia_r;
    case (op_r)
      OP_COPY:  wr_data = rd_b;
      OP_LOAD:  wr_data = imm64[DATA_WIDTH-1:0];
      OP_INPUT: wr_data = ent64[DATA_WIDTH-1:0];
      default:  wr_data = alu_res;
    endcase
    // divide writes the remainder second; same register ends at zero
    if (state_r == S_WB2) begin
      wr_data = (ia_r == ib_r) ? '0 : alu_rem;
    end
  end

  always_comb begin
    case (code_r)
      COND_ALWAYS: taken = 1'b1;
      COND_ZERO:   taken = (sign_r == FLAG_ZERO);
      COND_NZERO:  taken = (sign_r != FLAG_ZERO);
      COND_POS:    taken = (sign_r == FLAG_POS);
      COND_NEG:    taken = (sign_r == FLAG_NEG);
      COND_NNEG:   taken = (sign_r != FLAG_NEG);
      COND_NPOS:   taken = (sign_r != FLAG_POS);
      default:     taken = 1'b0;
    endcase
    if (op_r != OP_JUMP) begin
      taken = 1'b0;
    end
    case (op_r)
      OP_ADD, OP_SUB, OP_MUL, OP_CMP: flag_new = flag_of(alu_res);
      OP_DIV: begin
        if (derr) begin
          flag_new = sign_r;
        end else begin
          flag_new = (ia_r == ib_r) ? FLAG_ZERO : flag_of(alu_res);
        end
      end
      default: flag_new = sign_r;
    endcase
  end

  assign fin_load = (state_r == S_FIN) && (!ovalid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD, OP_SUB, OP_MUL, OP_CMP: state_nxt = S_ALU;
          OP_DIV:  state_nxt = derr ? S_FIN : S_ALU;
          OP_COPY, OP_LOAD, OP_INPUT: state_nxt = S_WB1;
          default: state_nxt = S_FIN;
        endcase
      end
      S_ALU: begin
        if (alu_done) begin
          state_nxt = (op_r == OP_CMP) ? S_FIN : S_WB1;
        end
      end
      S_WB1:   state_nxt = (op_r == OP_DIV) ? S_WB2 : S_FIN;
      S_WB2:   state_nxt = S_FIN;
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sign_r   <= FLAG_ZERO;
      pc_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_load) begin
        ovalid_r <= 1'b1;
        sign_r   <= flag_new;
        pc_r     <= taken ? (pc_r + imm_r) : (pc_r + 1'b1);
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.func;
      code_r <= in_ch.first_reg;
      ia_r   <= reg_sel(in_ch.first_reg);
      ib_r   <= reg_sel(in_ch.second_reg);
      imm_r  <= in_ch.immediate;
      ent_r  <= in_ch.entered_value;
    end
    if (fin_load) begin
      oshown_v_r <= (op_r == OP_OUTPUT);
      oshown_r   <= (op_r == OP_OUTPUT) ? a64[VALUE_W-1:0] : '0;
      otaken_r   <= taken;
      onext_r    <= taken ? (pc_r + imm_r) : (pc_r + 1'b1);
      ohalt_r    <= (op_r == OP_HALT);
      oderr_r    <= derr;
      oflag_r    <= flag_new;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.shown_valid  = oshown_v_r;
  assign out_ch.shown_value  = oshown_r;
  assign out_ch.branch_taken = otaken_r;
  assign out_ch.next_index   = onext_r;
  assign out_ch.halted       = ohalt_r;
  assign out_ch.divide_error = oderr_r;
  assign out_ch.sign_flag    = oflag_r;

endmodule
`default_nettype wire

FILE: design/rvx_checker.sv
// Port-level checker for the register machine execute unit, bound to the top level
`default_nettype none
`include "register_vm_execute_unit_macros.svh"
module rvx_checker import rvx_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 shown_valid,
  input wire logic [VALUE_W-1:0]   shown_value,
  input wire logic                 branch_taken,
  input wire logic [INDEX_W-1:0]   next_index,
  input wire logic                 halted,
  input wire logic                 divide_error,
  input wire logic [FLAG_W-1:0]    sign_flag
);

  `RVX_ASSERT(out_hold_a, out_valid && !out_ready |=> out_valid, "result word dropped")
  `RVX_ASSERT(out_stable_a, out_valid && !out_ready |=> $stable(next_index) && $stable(shown_value) && $stable(sign_flag), "stalled result changed")
  `RVX_ASSERT(one_at_a_time_a, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `RVX_ASSERT(flag_code_a, out_valid |-> sign_flag != 2'd3, "bad flag code")
  `RVX_ASSERT_ALWAYS(excl_a, out_valid && halted |-> !(branch_taken || shown_valid || divide_error), "halt with other status")

endmodule

bind register_vm_execute_unit rvx_checker u_rvx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .shown_valid (out_ch.shown_valid),
  .shown_value (out_ch.shown_value),
  .branch_taken(out_ch.branch_taken),
  .next_index  (out_ch.next_index),
  .halted      (out_ch.halted),
  .divide_error(out_ch.divide_error),
  .sign_flag   (out_ch.sign_flag)
);
`default_nettype wire
